@@ design/tcwts_pkg.sv @@
`timescale 1ns / 1ps

package tcwts_pkg;

   localparam int READING_W      = 12;
   localparam int NIBBLE_SHIFT   = 4;
   localparam int SENSOR_ADDR_W  = 7;
   localparam int RAW_BYTE_W     = 8;
   localparam int MEAN_W         = 16;
   localparam int COUNT_OUT_W    = 7;
   localparam int CSR_INDEX_W    = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_ADDR  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_ADDR = 1'b1;

   localparam logic [SENSOR_ADDR_W-1:0] FIRST_ADDR_RESET  = 7'd72;
   localparam logic [SENSOR_ADDR_W-1:0] SECOND_ADDR_RESET = 7'd73;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_OUTPUT = 4'b1000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ design/tcwts_divider.sv @@
`timescale 1ns / 1ps

module tcwts_divider
   import tcwts_pkg::*;
#(
   parameter int DVD_W = 20,
   parameter int DVS_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output div_status_type   status,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVS_W:0]    shifted;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DVS_W'(shifted - {1'b0, dvs_ff}) : shifted[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

@@ design/two_channel_window_temperature_stats.sv @@
// Flow: an accepted matching item passes ST_READ, then the bit-serial mean divider in ST_DIVIDE,
//   then waits in ST_OUTPUT; an item whose address matches no channel goes straight to ST_OUTPUT.
// Throughput: one item at a time; req_tready is high only in ST_IDLE, so a new item is taken
//   only after the response to the last one has been accepted with rsp_tready. The mean divider
//   has DVD_W = 16 + bits of WINDOW+1 (20 at WINDOW = 10).
// Reset: synchronous, active high; clears counts, totals, positions and handshakes and
//   restores the sensor addresses to 72 and 73. Window memory needs no clearing pass.
`timescale 1ns / 1ps

module two_channel_window_temperature_stats
   import tcwts_pkg::*;
#(
   parameter int WINDOW = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   // csr
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [SENSOR_ADDR_W-1:0] csr_wdata,
   // request: [6:0] sensor_address, [14:7] raw_high_byte, [22:15] raw_low_byte
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [23:0]              req_tdata,
   // response: [11:0] min_reading, [23:12] max_reading, [39:24] mean_tenths,
   //           [46:40] valid_count
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [47:0]              rsp_tdata,
   // response user: [0] accepted, [1] channel_index
   output logic [1:0]               rsp_tuser
);

   localparam int ADDR_W = $clog2(2 * WINDOW);
   localparam int POS_W  = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int TOT_W  = READING_W + CNT_W;
   localparam int DVD_W  = TOT_W + 4;

   state_type state_ff, state_in;

   logic [SENSOR_ADDR_W-1:0] addr0_ff, addr1_ff;

   logic [POS_W-1:0]     pos_ff   [2];
   logic [CNT_W-1:0]     fill_ff  [2];
   logic [TOT_W-1:0]     total_ff [2];
   logic [READING_W-1:0] low_ff   [2];
   logic [READING_W-1:0] high_ff  [2];

   logic [READING_W-1:0] win_mem [2*WINDOW];
   logic [READING_W-1:0] rd_data_ff;

   logic                 ch_ff;
   logic [ADDR_W-1:0]    slot_ff;
   logic [READING_W-1:0] reading_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [47:0]          rsp_data_ff;
   logic [1:0]           rsp_user_ff;

   logic [SENSOR_ADDR_W-1:0] req_addr;
   logic [READING_W-1:0]     req_reading;
   logic                     req_fire, match0, match1, req_match, req_ch;
   logic [ADDR_W-1:0]        req_slot;

   logic                 full;
   logic [TOT_W-1:0]     total_kept, total_new;
   logic [CNT_W-1:0]     fill_new;
   logic [READING_W-1:0] low_new, high_new;
   logic [DVD_W-1:0]     dividend;
   logic [POS_W-1:0]     pos_new;

   div_status_type   div_stat;
   logic [DVD_W-1:0] div_quo;
   logic             div_start;

   assign req_addr    = req_tdata[6:0];
   assign req_reading = {req_tdata[14:7], req_tdata[22:15+NIBBLE_SHIFT]};
   assign req_tready  = state_ff == ST_IDLE;
   assign req_fire    = req_tvalid && req_tready;
   assign match0      = req_addr == addr0_ff;
   assign match1      = req_addr == addr1_ff;
   assign req_match   = match0 || match1;
   assign req_ch      = !match0;
   assign req_slot    = req_ch ? ADDR_W'(WINDOW) + ADDR_W'(pos_ff[1]) : ADDR_W'(pos_ff[0]);

   // read-modify of the selected channel; memory data arrives in ST_READ
   assign full       = fill_ff[ch_ff] == CNT_W'(WINDOW);
   assign total_kept = full ? total_ff[ch_ff] - TOT_W'(rd_data_ff) : total_ff[ch_ff];
   assign total_new  = total_kept + TOT_W'(reading_ff);
   assign fill_new   = full ? fill_ff[ch_ff] : fill_ff[ch_ff] + 1'b1;
   assign pos_new    = (pos_ff[ch_ff] == POS_W'(WINDOW - 1)) ? '0 : pos_ff[ch_ff] + 1'b1;
   assign low_new    = (fill_ff[ch_ff] == '0 || reading_ff < low_ff[ch_ff])
                       ? reading_ff : low_ff[ch_ff];
   assign high_new   = (fill_ff[ch_ff] == '0 || reading_ff > high_ff[ch_ff])
                       ? reading_ff : high_ff[ch_ff];
   assign dividend   = (DVD_W'(total_new) << 3) + (DVD_W'(total_new) << 1);
   assign div_start  = state_ff == ST_READ;

   tcwts_divider #(
      .DVD_W (DVD_W),
      .DVS_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (fill_new),
      .status   (div_stat),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_match) begin
                  state_in = ST_READ;
               end else begin
                  state_in     = ST_OUTPUT;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in     = ST_OUTPUT;
               rsp_valid_in = 1'b1;
            end
         end
         ST_OUTPUT: begin
            if (rsp_tready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         addr0_ff     <= FIRST_ADDR_RESET;
         addr1_ff     <= SECOND_ADDR_RESET;
         for (int c = 0; c < 2; c++) begin
            pos_ff[c]   <= '0;
            fill_ff[c]  <= '0;
            total_ff[c] <= '0;
            low_ff[c]   <= '0;
            high_ff[c]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FIRST_ADDR:  addr0_ff <= csr_wdata;
               CSR_SECOND_ADDR: addr1_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == ST_READ) begin
            pos_ff[ch_ff]   <= pos_new;
            fill_ff[ch_ff]  <= fill_new;
            total_ff[ch_ff] <= total_new;
            low_ff[ch_ff]   <= low_new;
            high_ff[ch_ff]  <= high_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         win_mem[slot_ff] <= reading_ff;
      end
      if (req_fire && req_match) begin
         rd_data_ff <= win_mem[req_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff      <= req_ch;
         slot_ff    <= req_slot;
         reading_ff <= req_reading;
         if (!req_match) begin
            rsp_data_ff <= '0;
            rsp_user_ff <= '0;
         end
      end
      if (state_ff == ST_DIVIDE && div_stat.done) begin
         rsp_data_ff <= {1'b0, COUNT_OUT_W'(fill_ff[ch_ff]), MEAN_W'(div_quo),
                         high_ff[ch_ff], low_ff[ch_ff]};
         rsp_user_ff <= {ch_ff, 1'b1};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff[0] <= CNT_W'(WINDOW) && fill_ff[1] <= CNT_W'(WINDOW))
      else $error("fill count above window");

   a_valid_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid == (state_ff == ST_OUTPUT))
      else $error("response valid outside output state");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ST_DIVIDE)
      else $error("divider busy outside divide state");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> div_stat.busy)
      else $error("divider did not start");

   a_accepted_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tdata[46:40] != '0)
      else $error("accepted item with empty window");

endmodule

@@ test/stats_checker.sv @@
`timescale 1ns / 1ps

module stats_checker
   import tcwts_pkg::*;
#(
   parameter int WINDOW = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [SENSOR_ADDR_W-1:0] csr_wdata,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [23:0]              req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [47:0]              rsp_tdata,
   input  logic [1:0]               rsp_tuser,
   output int                       fail_count,
   output int                       pending
);

   typedef struct packed {
      logic                   accepted;
      logic                   channel;
      logic [READING_W-1:0]   lowest;
      logic [READING_W-1:0]   highest;
      logic [MEAN_W-1:0]      mean_tenths;
      logic [COUNT_OUT_W-1:0] count;
   } channel_stats_type;

   logic [SENSOR_ADDR_W-1:0] chan_addr [2];
   logic [READING_W-1:0]     history [2][WINDOW];
   int unsigned              next_slot [2];
   int unsigned              fill [2];
   int unsigned              total [2];
   logic [READING_W-1:0]     lowest [2];
   logic [READING_W-1:0]     highest [2];

   channel_stats_type expected_stats [$];

   task automatic clear_channels();
      chan_addr[0] = FIRST_ADDR_RESET;
      chan_addr[1] = SECOND_ADDR_RESET;
      for (int c = 0; c < 2; c++) begin
         for (int i = 0; i < WINDOW; i++) history[c][i] = '0;
         next_slot[c] = 0;
         fill[c]      = 0;
         total[c]     = 0;
         lowest[c]    = '0;
         highest[c]   = '0;
      end
   endtask

   // Update the channel statistics for one reading and return the result.
   function automatic channel_stats_type predict_stats(
      logic [SENSOR_ADDR_W-1:0] addr,
      logic [RAW_BYTE_W-1:0]    hi,
      logic [RAW_BYTE_W-1:0]    lo
   );
      logic [READING_W-1:0] reading;
      int unsigned          ch;
      int unsigned          pos;
      channel_stats_type    res;
      reading = {hi, lo[7:4]};
      res     = '0;
      if (addr == chan_addr[0]) begin
         ch = 0;
      end else if (addr == chan_addr[1]) begin
         ch = 1;
      end else begin
         return res;
      end
      pos = next_slot[ch];
      if (fill[ch] >= WINDOW) total[ch] -= history[ch][pos];
      history[ch][pos] = reading;
      total[ch]       += reading;
      next_slot[ch]    = (pos + 1 >= WINDOW) ? 0 : pos + 1;
      if (fill[ch] == 0) begin
         lowest[ch]  = reading;
         highest[ch] = reading;
      end else begin
         if (reading < lowest[ch]) lowest[ch] = reading;
         if (reading > highest[ch]) highest[ch] = reading;
      end
      if (fill[ch] < WINDOW) fill[ch]++;
      res.accepted    = 1'b1;
      res.channel     = ch[0];
      res.lowest      = lowest[ch];
      res.highest     = highest[ch];
      res.mean_tenths = MEAN_W'((total[ch] * 10) / fill[ch]);
      res.count       = COUNT_OUT_W'(fill[ch]);
      return res;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      channel_stats_type want;
      if (reset) begin
         clear_channels();
         expected_stats.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FIRST_ADDR: begin
                  chan_addr[0] = csr_wdata;
               end
               CSR_SECOND_ADDR: begin
                  chan_addr[1] = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_stats.push_back(predict_stats(req_tdata[6:0], req_tdata[14:7],
                                                   req_tdata[22:15]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_stats.size() == 0) begin
               $display("%0t: unexpected item, expected none, got tuser %h tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_stats.pop_front();
               check_field("accepted", 32'(want.accepted), 32'(rsp_tuser[0]));
               check_field("channel_index", 32'(want.channel), 32'(rsp_tuser[1]));
               check_field("min_reading", 32'(want.lowest), 32'(rsp_tdata[11:0]));
               check_field("max_reading", 32'(want.highest), 32'(rsp_tdata[23:12]));
               check_field("mean_tenths", 32'(want.mean_tenths), 32'(rsp_tdata[39:24]));
               check_field("valid_count", 32'(want.count), 32'(rsp_tdata[46:40]));
            end
         end
      end
      pending = expected_stats.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench
   import tcwts_pkg::*;
();

   localparam int WINDOW      = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 30;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index  = CSR_FIRST_ADDR;
   logic [SENSOR_ADDR_W-1:0] csr_wdata  = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [23:0]              req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [47:0]              rsp_tdata;
   logic [1:0]               rsp_tuser;

   int fail_count;
   int pending;
   int cycle_count   = 0;
   bit send_burst    = 1'b0;
   bit receive_burst = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   two_channel_window_temperature_stats #(.WINDOW(WINDOW)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   stats_checker #(.WINDOW(WINDOW)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("two_channel_window_temperature_stats regression: fail");
         $finish;
      end
   end

   task automatic send_reading(logic [SENSOR_ADDR_W-1:0] addr, logic [RAW_BYTE_W-1:0] hi,
                               logic [RAW_BYTE_W-1:0] lo);
      int gap;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, lo, hi, addr};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold until every reading is answered, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_addresses(logic [SENSOR_ADDR_W-1:0] a0, logic [SENSOR_ADDR_W-1:0] a1);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIRST_ADDR;
      csr_wdata <= a0;
      @(posedge clock);
      csr_index <= CSR_SECOND_ADDR;
      csr_wdata <= a1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_readings(int n, logic [SENSOR_ADDR_W-1:0] a0,
                                  logic [SENSOR_ADDR_W-1:0] a1);
      logic [SENSOR_ADDR_W-1:0] addr;
      logic [RAW_BYTE_W-1:0]    hi;
      logic [RAW_BYTE_W-1:0]    lo;
      int                       sel;
      int                       shape;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) addr = a0;
         else if (sel < 8) addr = a1;
         else addr = SENSOR_ADDR_W'($urandom_range(0, 127));
         shape = $urandom_range(0, 15);
         if (shape == 0) begin
            hi = '0;
            lo = '0;
         end else if (shape == 1) begin
            hi = '1;
            lo = '1;
         end else begin
            hi = RAW_BYTE_W'($urandom_range(0, 255));
            lo = RAW_BYTE_W'($urandom_range(0, 255));
         end
         send_reading(addr, hi, lo);
      end
   endtask

   initial begin
      int responses;
      int hold;
      responses = 0;
      forever begin
         if ($urandom_range(0, 39) == 0) receive_burst = !receive_burst;
         hold = receive_burst ? 0 : $urandom_range(0, 13);
         if (responses == 300) hold = 400;
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         responses++;
      end
   end

   initial begin
      logic [SENSOR_ADDR_W-1:0] a0;
      logic [SENSOR_ADDR_W-1:0] a1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset addresses: extremes, ignored low nibble, unmatched, window wrap
      send_reading(FIRST_ADDR_RESET, 8'h00, 8'h00);
      send_reading(FIRST_ADDR_RESET, 8'hFF, 8'hFF);
      send_reading(FIRST_ADDR_RESET, 8'h80, 8'h0F);
      send_reading(SECOND_ADDR_RESET, 8'h12, 8'h3C);
      send_reading(7'd0, 8'hFF, 8'hFF);
      send_reading(7'd127, 8'hAA, 8'h55);
      send_reading(SECOND_ADDR_RESET, 8'hFF, 8'hF0);
      for (int i = 0; i < 12; i++) begin
         send_reading(FIRST_ADDR_RESET, RAW_BYTE_W'($urandom_range(0, 255)),
                      RAW_BYTE_W'($urandom_range(0, 255)));
      end
      send_reading(SECOND_ADDR_RESET, 8'h00, 8'h0F);
      drain();

      set_addresses(7'd0, 7'd127);
      random_readings(220, 7'd0, 7'd127);
      drain();

      set_addresses(7'd127, 7'd0);
      random_readings(220, 7'd127, 7'd0);
      drain();

      // equal addresses: channel zero wins
      set_addresses(7'd5, 7'd5);
      random_readings(200, 7'd5, 7'd5);
      drain();

      for (int p = 0; p < 3; p++) begin
         a0 = SENSOR_ADDR_W'($urandom_range(0, 127));
         a1 = SENSOR_ADDR_W'($urandom_range(0, 127));
         set_addresses(a0, a1);
         random_readings(230, a0, a1);
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("two_channel_window_temperature_stats regression: pass");
      end else begin
         $display("two_channel_window_temperature_stats regression: fail");
      end
      $finish;
   end

endmodule
